### hw/rtl/cdq_pkg.sv
// Shared types, constants and opcodes for the circular deque.
// Used by cdq_ctrl, cdq_datapath and circular_deque; no dependencies.
`timescale 1ns / 1ps

package cdq_pkg;

    // Ring depth and derived widths
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_W = 5;
    localparam int CMP_W = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;
    localparam int WORD_W = 32;

    // Capacity after reset: depth, clamped to what the register can hold
    localparam int CAP_RESET = (DEPTH > 31) ? 31 : DEPTH;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CAP_W-1:0]         cap_t;
    typedef logic [CMP_W-1:0]         cmp_t;
    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOOK,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture an accepted item
        logic exec;       // apply the operation, issue pop read / push write
        logic look;       // read front and rear, capture popped word
        logic cfg_write;  // load capacity and empty the deque
    } cmd_t;

endpackage

### hw/rtl/cdq_ctrl.sv
// Sequencing state machine for the circular deque.
// Depends on cdq_pkg (state and command types).
`timescale 1ns / 1ps

module cdq_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          cfg_valid,
    output logic          busy,
    output logic          done,
    output logic          cfg_ready,
    output cdq_pkg::cmd_t cmd
);

    cdq_pkg::state_t state_reg;
    cdq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        busy          = 1'b0;
        done          = 1'b0;
        cfg_ready     = 1'b0;
        cmd           = '0;
        case (state_reg)
            cdq_pkg::S_IDLE:
            begin
                cfg_ready     = 1'b1;
                cmd.cfg_write = cfg_valid;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = cdq_pkg::S_EXEC;
                end
            end
            cdq_pkg::S_EXEC:
            begin
                busy       = 1'b1;
                cmd.exec   = 1'b1;
                state_next = cdq_pkg::S_LOOK;
            end
            cdq_pkg::S_LOOK:
            begin
                busy       = 1'b1;
                cmd.look   = 1'b1;
                state_next = cdq_pkg::S_DONE;
            end
            cdq_pkg::S_DONE:
            begin
                // result beat; a new item may be taken in the same cycle
                done = 1'b1;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = cdq_pkg::S_EXEC;
                end
                else
                begin
                    state_next = cdq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cdq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/cdq_datapath.sv
// Ring store, index/occupancy registers and result registers of the deque.
// Depends on cdq_pkg; driven by commands from cdq_ctrl.
`timescale 1ns / 1ps

module cdq_datapath
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cdq_pkg::cmd_t         cmd,
    input  logic [1:0]            opcode,
    input  logic signed [31:0]    push_value,
    input  logic [4:0]            cfg_data,
    output logic [1:0]            status,
    output logic signed [31:0]    popped_value,
    output logic signed [31:0]    front_value,
    output logic signed [31:0]    rear_value,
    output logic                  is_empty,
    output logic                  is_full
);

    // item registers
    cdq_pkg::op_t  op_reg;
    cdq_pkg::word_t val_reg;

    // deque state
    cdq_pkg::idx_t head_reg, head_next;
    cdq_pkg::idx_t tail_reg, tail_next;
    cdq_pkg::cap_t occ_reg, occ_next;
    cdq_pkg::cap_t cap_reg;

    // result state
    cdq_pkg::status_t status_reg, status_next;
    logic             pop_ok_reg, pop_ok_next;
    cdq_pkg::word_t   popped_reg;

    // ring store with registered reads
    cdq_pkg::word_t ring_reg [cdq_pkg::DEPTH];
    cdq_pkg::word_t rd_a_reg;
    cdq_pkg::word_t rd_b_reg;

    cdq_pkg::cap_t cap;
    cdq_pkg::idx_t cap_m1;
    cdq_pkg::idx_t head_inc, head_dec, tail_inc, tail_dec;
    cdq_pkg::idx_t waddr, raddr, addr_a;
    logic          we;
    logic          occ_zero, occ_full;

    // effective capacity: zero acts as one, clamp at depth
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap = cdq_pkg::cap_t'(1);
        end
        else if (cdq_pkg::cmp_t'(cap_reg) > cdq_pkg::cmp_t'(cdq_pkg::DEPTH))
        begin
            cap = cdq_pkg::cap_t'(cdq_pkg::DEPTH);
        end
        else
        begin
            cap = cap_reg;
        end
    end

    assign cap_m1   = cdq_pkg::idx_t'(cdq_pkg::cmp_t'(cap) - cdq_pkg::cmp_t'(1));
    assign occ_zero = (occ_reg == '0);
    assign occ_full = (occ_reg >= cap);

    // wrapping index moves
    always_comb
    begin
        head_dec = (head_reg == '0) ? cap_m1 : head_reg - cdq_pkg::idx_t'(1);
        tail_dec = (tail_reg == '0) ? cap_m1 : tail_reg - cdq_pkg::idx_t'(1);
        head_inc = ((cdq_pkg::cmp_t'(head_reg) + cdq_pkg::cmp_t'(1)) >= cdq_pkg::cmp_t'(cap))
                   ? '0 : head_reg + cdq_pkg::idx_t'(1);
        tail_inc = ((cdq_pkg::cmp_t'(tail_reg) + cdq_pkg::cmp_t'(1)) >= cdq_pkg::cmp_t'(cap))
                   ? '0 : tail_reg + cdq_pkg::idx_t'(1);
    end

    // operation step
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        occ_next    = occ_reg;
        status_next = status_reg;
        pop_ok_next = pop_ok_reg;
        we          = 1'b0;
        waddr       = head_reg;
        raddr       = head_reg;
        if (cmd.exec)
        begin
            status_next = cdq_pkg::ST_DONE;
            pop_ok_next = 1'b0;
            case (op_reg)
                cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR:
                begin
                    if (occ_full)
                    begin
                        status_next = cdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        we       = 1'b1;
                        occ_next = occ_reg + cdq_pkg::cap_t'(1);
                        if (occ_zero)
                        begin
                            head_next = '0;
                            tail_next = '0;
                            waddr     = '0;
                        end
                        else if (op_reg == cdq_pkg::OP_PUSH_FRONT)
                        begin
                            head_next = head_dec;
                            waddr     = head_dec;
                        end
                        else
                        begin
                            tail_next = tail_inc;
                            waddr     = tail_inc;
                        end
                    end
                end
                cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR:
                begin
                    if (occ_zero)
                    begin
                        status_next = cdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        pop_ok_next = 1'b1;
                        occ_next    = occ_reg - cdq_pkg::cap_t'(1);
                        if (op_reg == cdq_pkg::OP_POP_FRONT)
                        begin
                            raddr     = head_reg;
                            head_next = head_inc;
                        end
                        else
                        begin
                            raddr     = tail_reg;
                            tail_next = tail_dec;
                        end
                        // last entry gone: back to slot 0
                        if (occ_reg == cdq_pkg::cap_t'(1))
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                    end
                end
                default:
                begin
                    status_next = cdq_pkg::ST_DONE;
                end
            endcase
        end
    end

    // port A: pop slot during exec, front during look; port B: rear
    assign addr_a = cmd.look ? head_reg : raddr;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ring_reg[waddr] <= val_reg;
        end
        rd_a_reg <= ring_reg[addr_a];
        rd_b_reg <= ring_reg[tail_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= cdq_pkg::op_t'(opcode);
            val_reg <= push_value;
        end
        if (cmd.look)
        begin
            popped_reg <= pop_ok_reg ? rd_a_reg : '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            occ_reg    <= '0;
            cap_reg    <= cdq_pkg::cap_t'(cdq_pkg::CAP_RESET);
            status_reg <= cdq_pkg::ST_DONE;
            pop_ok_reg <= 1'b0;
        end
        else if (cmd.cfg_write)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
            cap_reg  <= cfg_data;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            occ_reg    <= occ_next;
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign front_value  = occ_zero ? '1 : rd_a_reg;
    assign rear_value   = occ_zero ? '1 : rd_b_reg;
    assign is_empty     = occ_zero;
    assign is_full      = occ_full;

endmodule

### hw/rtl/circular_deque.sv
// Circular double-ended queue: an accepted start leads through the exec and look
// states to the done beat; a new start is taken in the done cycle, not while busy.
// The pace is set by the ring store's read ports: exec applies the
// operation (pop read or push write), look reads front and rear, done presents.
// Reset: deque empty, capacity = 16, ring contents undefined; no stall input.
// Depends on cdq_pkg, cdq_ctrl and cdq_datapath.
`timescale 1ns / 1ps

module circular_deque
(
    input  logic               clk,
    input  logic               rst_n,

    // command channel
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] push_value,

    // result beat, one cycle wide, marked by done
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] popped_value,
    output logic signed [31:0] front_value,
    output logic signed [31:0] rear_value,
    output logic               is_empty,
    output logic               is_full,

    // capacity write channel; a write empties the deque
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         cfg_data
);

    cdq_pkg::cmd_t cmd;

    // sequencer: idle -> exec -> look -> done
    cdq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .busy      (busy),
        .done      (done),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    // ring store, head/tail/occupancy, result registers
    cdq_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .opcode       (opcode),
        .push_value   (push_value),
        .cfg_data     (cfg_data),
        .status       (status),
        .popped_value (popped_value),
        .front_value  (front_value),
        .rear_value   (rear_value),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    // every accepted item gets its result beat after the exec and look states
    a_item_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("accepted item produced no result beat");

    // an empty deque reports -1 at both ends
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_empty) |-> (front_value == -32'sd1 && rear_value == -32'sd1))
        else $error("empty deque shows a front or rear value");

    // a refused push means the deque is full
    a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == cdq_pkg::ST_FULL) |-> is_full)
        else $error("push refused while not full");

    // a capacity write leaves the deque empty
    a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> is_empty)
        else $error("deque not empty after capacity write");

endmodule
